// ----- hdl/shortest_job_first_queue_defines.svh -----
// Assertion macros shared by the checker of the shortest-job-first queue.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef SHORTEST_JOB_FIRST_QUEUE_DEFINES_SVH
`define SHORTEST_JOB_FIRST_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SJFQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SJFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sjfq_pkg.sv -----
// Package of the shortest-job-first queue: depth, widths, codes and types.
// Depends on nothing; used by every module of the block.
package sjfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int HANDLE_W    = 16;
    localparam int OCC_W       = 5;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_CLOSED = 2'd3
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic   insert_en;
        logic   pop_en;
        entry_t ins;
    } cell_ctl_t;

    // Count narrowed or widened to the occupancy port.
    function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] cnt);
        to_occ = OCC_W'(cnt);
    endfunction

endpackage

// ----- hdl/sjfq_cell.sv -----
// One cell of the sorted shift-register queue: holds one key and handle.
// Depends on sjfq_pkg.
module sjfq_cell
(
    input  logic               clk,
    input  sjfq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  logic               left_take,
    input  sjfq_pkg::entry_t   left_entry,
    input  sjfq_pkg::entry_t   right_entry,
    output logic               take,
    output sjfq_pkg::entry_t   entry
);

    sjfq_pkg::entry_t entry_reg;
    sjfq_pkg::entry_t entry_next;

    // A cell takes part in an insert when it is empty or holds a larger key,
    // so equal keys keep the older entry in front.
    assign take = !(occupied && ($signed(entry_reg.key) <= $signed(ctl.ins.key)));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert_en && take)
        begin
            entry_next = left_take ? left_entry : ctl.ins;
        end
        else if (ctl.pop_en)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- hdl/shortest_job_first_queue.sv -----
// Top level of the shortest-job-first queue: control, count and cell row.
// Depends on sjfq_pkg and sjfq_cell.
//
//  Channel   | Handshake        | Payload
//  ----------+------------------+------------------------------------------
//  request   | start / busy     | opcode, job_size, job_handle
//  result    | done (strobe)    | status, out_size, out_handle, occupancy
//  config    | cfg_we           | cfg_wdata (closed bit)
//
// One request is taken every clock cycle; busy is never raised. The result
// appears on the cycle after the request is taken and is held for exactly
// one cycle, marked by done. The receiver cannot stall the result port.
// Reset clears the count and the closed register; the cell contents are not
// cleared because a cell beyond the count is never read.
module shortest_job_first_queue
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            opcode,
    input  logic signed [sjfq_pkg::KEY_W-1:0] job_size,
    input  logic [sjfq_pkg::HANDLE_W-1:0]   job_handle,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    output logic                            done,
    output logic [1:0]                      status,
    output logic signed [sjfq_pkg::KEY_W-1:0] out_size,
    output logic [sjfq_pkg::HANDLE_W-1:0]   out_handle,
    output logic [sjfq_pkg::OCC_W-1:0]      occupancy
);

    localparam int DEPTH = sjfq_pkg::QUEUE_DEPTH;
    localparam int CNT_W = sjfq_pkg::CNT_W;

    logic                           closed_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic                           done_reg;
    sjfq_pkg::status_t              status_reg;
    sjfq_pkg::status_t              status_next;
    logic [sjfq_pkg::KEY_W-1:0]     size_reg;
    logic [sjfq_pkg::KEY_W-1:0]     size_next;
    logic [sjfq_pkg::HANDLE_W-1:0]  handle_reg;
    logic [sjfq_pkg::HANDLE_W-1:0]  handle_next;

    logic                           accept;
    logic                           full;
    logic                           empty;
    sjfq_pkg::cell_ctl_t            ctl;

    sjfq_pkg::entry_t               cell_entry [DEPTH];
    logic                           cell_take  [DEPTH];

    // Every request completes in the cycle after it is taken, so the request side never waits.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // An insert is dropped when the queue is closed or full; a pop of an
    // empty queue changes nothing. Closed wins over full.
    always_comb
    begin
        ctl.insert_en  = 1'b0;
        ctl.pop_en     = 1'b0;
        ctl.ins.key    = job_size;
        ctl.ins.handle = job_handle;
        count_next     = count_reg;
        status_next    = sjfq_pkg::ST_OK;
        size_next      = '0;
        handle_next    = '0;
        if (opcode == sjfq_pkg::OP_INSERT)
        begin
            if (closed_reg)
            begin
                status_next = sjfq_pkg::ST_CLOSED;
            end
            else if (full)
            begin
                status_next = sjfq_pkg::ST_FULL;
            end
            else
            begin
                ctl.insert_en = accept;
                count_next    = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = sjfq_pkg::ST_EMPTY;
            end
            else
            begin
                ctl.pop_en  = accept;
                count_next  = count_reg - CNT_W'(1);
                size_next   = cell_entry[0].key;
                handle_next = cell_entry[0].handle;
            end
        end
    end

    // The row of cells. Each cell shifts right on an insert when it and its
    // left neighbor both lie past the insert point, and shifts left on a pop.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             occupied;
        logic             left_take;
        sjfq_pkg::entry_t left_entry;
        sjfq_pkg::entry_t right_entry;

        assign occupied = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left_take  = 1'b0;
            assign left_entry = ctl.ins;
        end
        else
        begin : g_inner
            assign left_take  = cell_take[i-1];
            assign left_entry = cell_entry[i-1];
        end

        // The last cell has no right neighbor; after a pop it lies beyond
        // the count and is never read, so it simply keeps its value.
        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        sjfq_cell u_cell
        (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occupied),
            .left_take   (left_take),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .take        (cell_take[i]),
            .entry       (cell_entry[i])
        );
    end

    // Control state: closed flag, count and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                closed_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            done_reg <= accept;
        end
    end

    // Result payload is only meaningful while done is high.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            size_reg   <= size_next;
            handle_reg <= handle_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign out_size   = size_reg;
    assign out_handle = handle_reg;
    assign occupancy  = sjfq_pkg::to_occ(count_reg);

endmodule

// ----- hdl/sjfq_checker.sv -----
// Port-level checker for the shortest-job-first queue, bound to the top level.
// Depends on sjfq_pkg and shortest_job_first_queue_defines.svh.
`include "shortest_job_first_queue_defines.svh"

module sjfq_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            done,
    input  logic [1:0]                      status,
    input  logic signed [sjfq_pkg::KEY_W-1:0] out_size,
    input  logic [sjfq_pkg::HANDLE_W-1:0]   out_handle,
    input  logic [sjfq_pkg::OCC_W-1:0]      occupancy
);

    `SJFQ_ASSERT_NEXT(a_done_after_request, start && !busy, done, "request gave no result")

    `SJFQ_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done, "result without request")

    `SJFQ_ASSERT_SAME(a_fail_zero_payload, done && (status != sjfq_pkg::ST_OK), out_size == '0 && out_handle == '0, "failed request returned data")

    `SJFQ_ASSERT_SAME(a_empty_occupancy, done && (status == sjfq_pkg::ST_EMPTY), occupancy == '0, "empty status with jobs queued")

    `SJFQ_ASSERT_SAME(a_full_occupancy, done && (status == sjfq_pkg::ST_FULL), occupancy == sjfq_pkg::OCC_W'(sjfq_pkg::QUEUE_DEPTH), "full status below depth")

endmodule

bind shortest_job_first_queue sjfq_checker u_sjfq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .out_size   (out_size),
    .out_handle (out_handle),
    .occupancy  (occupancy)
);

// ----- tb/shortest_job_first_queue_tb.sv -----
// Self-checking testbench of the shortest-job-first queue: directed table, then random phases.
// Depends on sjfq_pkg and the shortest_job_first_queue module; reads no files.
// Every result is checked field by field against a typed expectation or a sorted-queue model kept in this file.
module shortest_job_first_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sjfq_pkg::*;

    // One expected result, in the order of the result ports.
    typedef struct packed {
        status_t             status;
        logic [KEY_W-1:0]    size;
        logic [HANDLE_W-1:0] handle;
        logic [OCC_W-1:0]    occ;
    } job_result_t;

    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_t;

    // A row of the directed table. A request row either carries a typed
    // expectation (pinned) or leaves the expectation to the queue model.
    // A config row writes closed_val into the closed register.
    typedef struct packed {
        row_kind_t           kind;
        opcode_t             op;
        logic [KEY_W-1:0]    size;
        logic [HANDLE_W-1:0] handle;
        logic                closed_val;
        logic                pinned;
        job_result_t         result;
    } stim_row_t;

    localparam job_result_t NO_RESULT = '{ST_OK, 32'h0, 16'h0, 5'd0};

    // The directed part. Extremes of the key go in first so that the most
    // negative key must come out ahead of everything, the two zero keys
    // check that ties leave in arrival order, and the closed register is
    // exercised with jobs still queued (they must drain) and on an empty
    // queue (an empty pop still reports empty, not closed).
    localparam int DIR_ROWS = 20;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_REQ, OP_POP,    32'h0000_0000, 16'h0000, 1'b0, 1'b1,
          '{ST_EMPTY, 32'h0, 16'h0, 5'd0}},
        '{ROW_REQ, OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 1'b1,
          '{ST_OK, 32'h0, 16'h0, 5'd1}},
        '{ROW_REQ, OP_INSERT, 32'h8000_0000, 16'h0000, 1'b0, 1'b1,
          '{ST_OK, 32'h0, 16'h0, 5'd2}},
        '{ROW_REQ, OP_INSERT, 32'h0000_0000, 16'h1234, 1'b0, 1'b1,
          '{ST_OK, 32'h0, 16'h0, 5'd3}},
        '{ROW_REQ, OP_INSERT, 32'h0000_0000, 16'h5678, 1'b0, 1'b1,
          '{ST_OK, 32'h0, 16'h0, 5'd4}},
        '{ROW_REQ, OP_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 1'b0, 1'b1,
          '{ST_OK, 32'h0, 16'h0, 5'd5}},
        '{ROW_REQ, OP_INSERT, 32'h0000_0001, 16'h5555, 1'b0, 1'b1,
          '{ST_OK, 32'h0, 16'h0, 5'd6}},
        '{ROW_REQ, OP_POP,    32'h0000_0000, 16'h0000, 1'b0, 1'b1,
          '{ST_OK, 32'h8000_0000, 16'h0000, 5'd5}},
        '{ROW_REQ, OP_POP,    32'h0000_0000, 16'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REQ, OP_POP,    32'h0000_0000, 16'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REQ, OP_POP,    32'h0000_0000, 16'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG, OP_INSERT, 32'h0000_0000, 16'h0000, 1'b1, 1'b0, NO_RESULT},
        '{ROW_REQ, OP_INSERT, 32'h0000_0040, 16'h0BEE, 1'b0, 1'b1,
          '{ST_CLOSED, 32'h0, 16'h0, 5'd2}},
        '{ROW_REQ, OP_POP,    32'h0000_0000, 16'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REQ, OP_POP,    32'h0000_0000, 16'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REQ, OP_POP,    32'h0000_0000, 16'h0000, 1'b0, 1'b1,
          '{ST_EMPTY, 32'h0, 16'h0, 5'd0}},
        '{ROW_REQ, OP_INSERT, 32'h8000_0000, 16'hFFFF, 1'b0, 1'b1,
          '{ST_CLOSED, 32'h0, 16'h0, 5'd0}},
        '{ROW_CFG, OP_INSERT, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REQ, OP_INSERT, 32'h1234_5678, 16'h0001, 1'b0, 1'b1,
          '{ST_OK, 32'h0, 16'h0, 5'd1}},
        '{ROW_REQ, OP_POP,    32'h0000_0000, 16'h0000, 1'b0, 1'b0, NO_RESULT}
    };

    // Random phases. Insert-heavy phases run the queue into full, pop-heavy
    // ones drain it to empty, and closed phases that follow an insert-heavy
    // phase see inserts against a full queue, where closed must win.
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 90;
    localparam logic PHASE_CLOSED [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                                                1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam int PHASE_INSERT_PCT [PHASES] = '{80, 50, 60, 15, 90, 30, 50, 10, 70, 50};
    // A phase with a cap of zero sends back-to-back requests throughout.
    localparam int PHASE_IDLE_MAX [PHASES] = '{3, 3, 3, 0, 3, 3, 0, 3, 3, 3};

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       start      = 1'b0;
    logic                       opcode     = 1'b0;
    logic signed [KEY_W-1:0]    job_size   = '0;
    logic [HANDLE_W-1:0]        job_handle = '0;
    logic                       cfg_we     = 1'b0;
    logic                       cfg_wdata  = 1'b0;
    logic                       busy;
    logic                       done;
    logic [1:0]                 status;
    logic signed [KEY_W-1:0]    out_size;
    logic [HANDLE_W-1:0]        out_handle;
    logic [OCC_W-1:0]           occupancy;

    // A typed expectation travels with its request, driven in the same step,
    // so the monitor sees it exactly when the request is taken.
    logic        pin_valid  = 1'b0;
    job_result_t pin_result = NO_RESULT;

    int idle_max = 3;

    // Queue model: sorted keys and handles, the count and the closed bit.
    logic signed [KEY_W-1:0] sjf_keys    [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]     sjf_handles [QUEUE_DEPTH];
    int                      sjf_count   = 0;
    logic                    closed_model = 1'b0;

    job_result_t pending_results [$];

    int mismatches     = 0;
    int requests_taken = 0;
    int ok_count       = 0;
    int empty_count    = 0;
    int full_count     = 0;
    int closed_count   = 0;

    shortest_job_first_queue u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .job_size   (job_size),
        .job_handle (job_handle),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .status     (status),
        .out_size   (out_size),
        .out_handle (out_handle),
        .occupancy  (occupancy)
    );

    always #5 clk = ~clk;

    // Applies one request to the queue model and returns the result it owes.
    // An insert walks past every key that is less than or equal to its own,
    // which is what keeps equal sizes in arrival order.
    function automatic job_result_t schedule_job(opcode_t op,
                                                 logic signed [KEY_W-1:0] size,
                                                 logic [HANDLE_W-1:0] handle);
        job_result_t r;
        int          pos;
        r = NO_RESULT;
        if (op == OP_INSERT)
        begin
            if (closed_model)
                r.status = ST_CLOSED;
            else if (sjf_count >= QUEUE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < sjf_count && sjf_keys[pos] <= size)
                    pos++;
                for (int i = sjf_count; i > pos; i--)
                begin
                    sjf_keys[i]    = sjf_keys[i-1];
                    sjf_handles[i] = sjf_handles[i-1];
                end
                sjf_keys[pos]    = size;
                sjf_handles[pos] = handle;
                sjf_count++;
            end
        end
        else if (sjf_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.size   = sjf_keys[0];
            r.handle = sjf_handles[0];
            for (int i = 1; i < sjf_count; i++)
            begin
                sjf_keys[i-1]    = sjf_keys[i];
                sjf_handles[i-1] = sjf_handles[i];
            end
            sjf_count--;
        end
        r.occ = OCC_W'(sjf_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Monitor. All sampling happens at the rising edge, before any update
    // that the edge itself schedules. A result strobed at this edge belongs
    // to a request taken at an earlier edge, so it is checked before the
    // request taken at this edge is predicted. The closed bit of the model
    // follows a register write at the edge that performs it.
    always @(posedge clk)
    begin : monitor
        job_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unrequested result", KEY_W'(status), '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", KEY_W'(status), KEY_W'(want.status));
                    if (out_size !== want.size)
                        report_mismatch("out_size", out_size, want.size);
                    if (out_handle !== want.handle)
                        report_mismatch("out_handle", KEY_W'(out_handle), KEY_W'(want.handle));
                    if (occupancy !== want.occ)
                        report_mismatch("occupancy", KEY_W'(occupancy), KEY_W'(want.occ));
                    case (want.status)
                        ST_OK:    ok_count++;
                        ST_EMPTY: empty_count++;
                        ST_FULL:  full_count++;
                        default:  closed_count++;
                    endcase
                end
            end
            if (start && !busy)
            begin
                // The model is stepped even for a typed row so that its
                // contents stay in line with the block.
                want = schedule_job(opcode_t'(opcode), job_size, job_handle);
                if (pin_valid)
                    want = pin_result;
                pending_results.push_back(want);
                requests_taken++;
            end
            if (cfg_we)
                closed_model = cfg_wdata;
        end
    end

    // Sends one request after a random pause and returns at the edge that
    // takes it. Start stays high on return so that a request that follows
    // without a pause goes out on the very next cycle.
    task automatic send_request(opcode_t op, logic [KEY_W-1:0] size,
                                logic [HANDLE_W-1:0] handle,
                                logic pinned, job_result_t result);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap != 0)
        begin
            start     <= 1'b0;
            pin_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        job_size   <= size;
        job_handle <= handle;
        pin_valid  <= pinned;
        pin_result <= result;
        do @(posedge clk); while (busy);
    endtask

    // Lowers start and waits until every owed result has come back.
    // Every request yields exactly one result, so nothing is left in flight.
    task automatic drain_requests();
        start     <= 1'b0;
        pin_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // The closed register is only written with the queue idle.
    task automatic write_closed(logic value);
        drain_requests();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Job sizes: a quarter fully random, a quarter at the extremes and the
    // rest in a narrow band around zero so that ties are frequent.
    function automatic logic [KEY_W-1:0] pick_size();
        int band;
        band = int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 3))
            0: return $urandom();
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return KEY_W'(band);
        endcase
    endfunction

    initial
    begin : stimulus
        stim_row_t row;
        opcode_t   op;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TABLE[i])
        begin
            row = DIR_TABLE[i];
            if (row.kind == ROW_CFG)
                write_closed(row.closed_val);
            else
                send_request(row.op, row.size, row.handle, row.pinned, row.result);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_closed(PHASE_CLOSED[p]);
            idle_max = PHASE_IDLE_MAX[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                op = ($urandom_range(0, 99) < PHASE_INSERT_PCT[p]) ? OP_INSERT : OP_POP;
                send_request(op, pick_size(), HANDLE_W'($urandom_range(0, 65535)),
                             1'b0, NO_RESULT);
            end
        end

        drain_requests();
        repeat (4) @(posedge clk);

        $display("Ran %0d requests: %0d completed, %0d empty pops, %0d full and %0d closed rejects.",
                 requests_taken, ok_count, empty_count, full_count, closed_count);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // This cap lies far beyond the length of the run.
    initial
    begin : watchdog
        #1_000_000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/sjfq_pkg.sv
hdl/sjfq_cell.sv
hdl/shortest_job_first_queue.sv
hdl/sjfq_checker.sv
tb/shortest_job_first_queue_tb.sv
